[rtl/binary_max_heap_queue_defines.svh]
// ============================================================================
// binary_max_heap_queue_defines.svh - assertion macros
// Shared property forms for the heap queue checker.
// ============================================================================
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HBQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication, disabled in reset
`define HBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

[rtl/hbq_pkg.sv]
// ============================================================================
// hbq_pkg - heap queue package
// Field widths, request and status codes, payload and control structs.
// ============================================================================
`default_nettype none

package hbq_pkg;

    localparam int KEY_W           = 32;
    localparam int HANDLE_W        = 16;
    localparam int COUNT_W         = 9;
    localparam int DEF_HEAP_DEPTH  = 256;
    localparam int DEF_HANDLE_BITS = 16;

    // request codes; code 3 behaves as a query
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [KEY_W-1:0] entry_key;
        logic [HANDLE_W-1:0] entry_handle;
    } t_req_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] popped_key;
        logic [HANDLE_W-1:0]     popped_handle;
        logic signed [KEY_W-1:0] top_key;
        logic [HANDLE_W-1:0]     top_handle;
        logic                    is_empty;
        logic [COUNT_W-1:0]      entry_count;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_LAST,
        S_DOWN_CHK,
        S_DOWN_CMP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // take the request on i_req
        logic load_carry;  // carried entry <= last slot read
        logic sel_parent;  // read port A addresses the parent
        logic wr_carry;    // carried entry into the hole, sift ends
        logic wr_up;       // parent moves down into the hole
        logic wr_down;     // larger child moves up into the hole
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_push;     // push request with room
        logic go_pop;      // pop request on a non-empty heap
        logic at_root;
        logic at_leaf;
        logic move_up;
        logic move_down;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/hbq_ctrl.sv]
// ============================================================================
// hbq_ctrl - heap queue controller
// Sequences accept, sift steps and the result strobe.
// ============================================================================
`default_nettype none

module hbq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire hbq_pkg::t_dp_stat i_stat,
    output hbq_pkg::t_dp_cmd       o_cmd,
    output logic                   busy,
    output logic                   o_done
);

    hbq_pkg::t_state r_state;
    hbq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hbq_pkg::S_IDLE: begin
                if (start) begin
                    if (i_stat.go_push) begin
                        n_state = hbq_pkg::S_PUSH_CHK;
                    end else if (i_stat.go_pop) begin
                        n_state = hbq_pkg::S_POP_LAST;
                    end else begin
                        n_state = hbq_pkg::S_DONE;
                    end
                end
            end
            hbq_pkg::S_PUSH_CHK: begin
                n_state = i_stat.at_root ? hbq_pkg::S_DONE : hbq_pkg::S_PUSH_CMP;
            end
            hbq_pkg::S_PUSH_CMP: begin
                n_state = i_stat.move_up ? hbq_pkg::S_PUSH_CHK : hbq_pkg::S_DONE;
            end
            hbq_pkg::S_POP_LAST: begin
                n_state = hbq_pkg::S_DOWN_CHK;
            end
            hbq_pkg::S_DOWN_CHK: begin
                n_state = i_stat.at_leaf ? hbq_pkg::S_DONE : hbq_pkg::S_DOWN_CMP;
            end
            hbq_pkg::S_DOWN_CMP: begin
                n_state = i_stat.move_down ? hbq_pkg::S_DOWN_CHK : hbq_pkg::S_DONE;
            end
            hbq_pkg::S_DONE: begin
                n_state = hbq_pkg::S_IDLE;
            end
            default: begin
                n_state = hbq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            hbq_pkg::S_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
            end
            hbq_pkg::S_PUSH_CHK: begin
                o_cmd.sel_parent = !i_stat.at_root;
                o_cmd.wr_carry   = i_stat.at_root;
            end
            hbq_pkg::S_PUSH_CMP: begin
                o_cmd.wr_up    = i_stat.move_up;
                o_cmd.wr_carry = !i_stat.move_up;
            end
            hbq_pkg::S_POP_LAST: begin
                o_cmd.load_carry = 1'b1;
            end
            hbq_pkg::S_DOWN_CHK: begin
                o_cmd.wr_carry = i_stat.at_leaf;
            end
            hbq_pkg::S_DOWN_CMP: begin
                o_cmd.wr_down  = i_stat.move_down;
                o_cmd.wr_carry = !i_stat.move_down;
            end
            hbq_pkg::S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/hbq_dp.sv]
// ============================================================================
// hbq_dp - heap queue datapath
// Entry memory, hole-based sift registers, root copy and result fields.
// ============================================================================
`default_nettype none

module hbq_dp #(
    parameter int HEAP_DEPTH  = hbq_pkg::DEF_HEAP_DEPTH,
    parameter int HANDLE_BITS = hbq_pkg::DEF_HANDLE_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hbq_pkg::t_req_item i_req,
    input  wire hbq_pkg::t_dp_cmd   i_cmd,
    output hbq_pkg::t_dp_stat       o_stat,
    output hbq_pkg::t_result        o_result
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int KW = hbq_pkg::KEY_W;
    localparam int HW = (HANDLE_BITS < hbq_pkg::HANDLE_W) ? HANDLE_BITS : hbq_pkg::HANDLE_W;

    // entry memory: one write port, two registered read ports
    logic signed [KW-1:0] key_mem [HEAP_DEPTH];
    logic [HW-1:0]        hdl_mem [HEAP_DEPTH];

    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    logic signed [KW-1:0] r_carry_key;
    logic [HW-1:0]        r_carry_hdl;
    logic signed [KW-1:0] r_rd_a_key;
    logic [HW-1:0]        r_rd_a_hdl;
    logic signed [KW-1:0] r_rd_b_key;
    logic [HW-1:0]        r_rd_b_hdl;
    logic signed [KW-1:0] r_top_key;
    logic [HW-1:0]        r_top_hdl;
    logic signed [KW-1:0] r_pop_key;
    logic [HW-1:0]        r_pop_hdl;
    logic [1:0]           r_status;

    logic [XW-1:0]        left_x;
    logic [XW-1:0]        right_x;
    logic [XW-1:0]        count_x;
    logic [AW-1:0]        parent;
    logic [AW-1:0]        last_addr;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic                 right_ok;
    logic                 l_gt;
    logic                 r_gt;
    logic signed [KW-1:0] best_key;
    logic                 is_full;
    logic                 is_empty;
    logic                 wr_en;
    logic signed [KW-1:0] wr_key;
    logic [HW-1:0]        wr_hdl;

    always_comb begin
        left_x    = XW'({r_pos, 1'b1});
        right_x   = left_x + XW'(1);
        count_x   = XW'(r_count);
        parent    = (r_pos - AW'(1)) >> 1;
        last_addr = AW'(r_count - CW'(1));
        rd_addr_a = i_cmd.accept ? last_addr :
                    (i_cmd.sel_parent ? parent : left_x[AW-1:0]);
        rd_addr_b = right_x[AW-1:0];
        right_ok  = right_x < count_x;
        l_gt      = r_rd_a_key > r_carry_key;
        best_key  = l_gt ? r_rd_a_key : r_carry_key;
        r_gt      = right_ok && (r_rd_b_key > best_key);
        is_full   = r_count == CW'(HEAP_DEPTH);
        is_empty  = r_count == CW'(0);
    end

    always_comb begin
        o_stat.go_push   = (i_req.req_type == hbq_pkg::REQ_PUSH) && !is_full;
        o_stat.go_pop    = (i_req.req_type == hbq_pkg::REQ_POP) && !is_empty;
        o_stat.at_root   = r_pos == AW'(0);
        o_stat.at_leaf   = left_x >= count_x;
        o_stat.move_up   = r_rd_a_key < r_carry_key;
        o_stat.move_down = l_gt || r_gt;
    end

    // the carried entry rides in a register; only the hole gets written
    always_comb begin
        wr_en = i_cmd.wr_carry || i_cmd.wr_up || i_cmd.wr_down;
        if (i_cmd.wr_carry) begin
            wr_key = r_carry_key;
            wr_hdl = r_carry_hdl;
        end else if (i_cmd.wr_down && r_gt) begin
            wr_key = r_rd_b_key;
            wr_hdl = r_rd_b_hdl;
        end else begin
            wr_key = r_rd_a_key;
            wr_hdl = r_rd_a_hdl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[r_pos] <= wr_key;
            hdl_mem[r_pos] <= wr_hdl;
        end
        r_rd_a_key <= key_mem[rd_addr_a];
        r_rd_a_hdl <= hdl_mem[rd_addr_a];
        r_rd_b_key <= key_mem[rd_addr_b];
        r_rd_b_hdl <= hdl_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && o_stat.go_push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.accept && o_stat.go_pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if ((i_req.req_type == hbq_pkg::REQ_PUSH) && is_full) begin
                r_status <= hbq_pkg::ST_PUSH_FULL;
            end else if ((i_req.req_type == hbq_pkg::REQ_POP) && is_empty) begin
                r_status <= hbq_pkg::ST_POP_EMPTY;
            end else begin
                r_status <= hbq_pkg::ST_OK;
            end
            r_pop_key <= o_stat.go_pop ? r_top_key : '0;
            r_pop_hdl <= o_stat.go_pop ? r_top_hdl : '0;
            if (o_stat.go_push) begin
                r_carry_key <= i_req.entry_key;
                r_carry_hdl <= i_req.entry_handle[HW-1:0];
                r_pos       <= AW'(r_count);
            end else begin
                r_pos       <= '0;
            end
        end else if (i_cmd.load_carry) begin
            r_carry_key <= r_rd_a_key;
            r_carry_hdl <= r_rd_a_hdl;
        end else if (i_cmd.wr_up) begin
            r_pos <= parent;
        end else if (i_cmd.wr_down) begin
            r_pos <= r_gt ? right_x[AW-1:0] : left_x[AW-1:0];
        end
        // root mirror for top-of-heap reporting
        if (wr_en && (r_pos == AW'(0))) begin
            r_top_key <= wr_key;
            r_top_hdl <= wr_hdl;
        end
    end

    always_comb begin
        o_result.status        = r_status;
        o_result.popped_key    = r_pop_key;
        o_result.popped_handle = hbq_pkg::HANDLE_W'(r_pop_hdl);
        o_result.top_key       = is_empty ? '0 : r_top_key;
        o_result.top_handle    = is_empty ? '0 : hbq_pkg::HANDLE_W'(r_top_hdl);
        o_result.is_empty      = is_empty;
        o_result.entry_count   = hbq_pkg::COUNT_W'(r_count);
    end

endmodule

`default_nettype wire

[rtl/binary_max_heap_queue.sv]
// Sequence: a query, a pop on empty or a push on full strobes in the cycle after accept; a push
// reads and compares one parent per level until the entry reaches the root or stops; a pop
// first reads the last slot into the carry, then sifts the hole down until a leaf or a stop.
// Each sift level is a registered memory read, then a compare and hole write.
// Throughput: the next start is taken the cycle after the strobe; the receiver cannot stall.
// Reset (synchronous, active low) empties the heap and idles the controller; memory keeps data.
// ============================================================================
// binary_max_heap_queue - priority queue on a binary max-heap
// Push, pop-max and query over (signed key, handle) entries in on-chip memory.
// ============================================================================
`default_nettype none

module binary_max_heap_queue #(
    parameter int HEAP_DEPTH  = hbq_pkg::DEF_HEAP_DEPTH,
    parameter int HANDLE_BITS = hbq_pkg::DEF_HANDLE_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request side: transfer when start is high and busy is low
    input  wire logic               start,
    input  wire hbq_pkg::t_req_item i_req,
    output logic                    busy,
    // result side: o_done marks a one-cycle transfer, no back-pressure
    output logic                    o_done,
    output hbq_pkg::t_result        o_result
);

    hbq_pkg::t_dp_cmd  cmd;
    hbq_pkg::t_dp_stat stat;

    // Controller: walks the sift one level per compare, decides when the
    // hole is final and raises the strobe in a state of its own.
    hbq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Datapath: the entry travels in a carry register while parents (push)
    // or the larger child (pop, left wins ties) move into the hole. A copy
    // of the root is kept in flops so pop and query need no extra read.
    hbq_dp #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[rtl/hbq_chk.sv]
// ============================================================================
// hbq_chk - heap queue port checker
// Watches handshake and result consistency at the top-level ports.
// ============================================================================
`default_nettype none

`include "binary_max_heap_queue_defines.svh"

module hbq_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire hbq_pkg::t_req_item i_req,
    input wire logic               busy,
    input wire logic               o_done,
    input wire hbq_pkg::t_result   o_result
);

    logic accepted;

    assign accepted = start && !busy;

    // an accepted request occupies the block next cycle
    `HBQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accepted, busy)
    // strobe only while a request is in flight, never two in a row
    `HBQ_ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `HBQ_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done && !busy)
    // empty heap reports zero count and zero top
    `HBQ_ASSERT_SAME(a_empty_top, i_clk, i_rst_n, o_done && o_result.is_empty, (o_result.entry_count == '0) && (o_result.top_key == '0) && (o_result.top_handle == '0))
    // failed requests carry no popped entry
    `HBQ_ASSERT_SAME(a_fail_nopop, i_clk, i_rst_n, o_done && (o_result.status != hbq_pkg::ST_OK), (o_result.popped_key == '0) && (o_result.popped_handle == '0))

endmodule

bind binary_max_heap_queue hbq_chk u_hbq_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_req    (i_req),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

[tb/tb_top.sv]
// ============================================================================
// tb_top - heap priority queue testbench
// Drives push, pop and query requests into the heap queue and checks every
// result strobe against an in-bench max-heap model, field by field.
// ============================================================================
module tb_top;

    import hbq_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int DEPTH = DEF_HEAP_DEPTH;

    // request code 3 is unused by the block and must act as a query
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // idle odds in percent for the request side
    localparam int IDLE_PCT = 8;

    // quiet time after the last result
    localparam int SETTLE_CYCLES = 40;

    // hard stop, several times the slowest legal run (~2k items)
    localparam int RUN_LIMIT = 5_000_000;

    // ------------------------------------------------------------------------
    // Clock and DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_req_item i_req   = '0;
    logic      busy;
    logic      o_done;
    t_result   o_result;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    binary_max_heap_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------------
    // Heap model: mirror of the array heap, slot 0 is the root.
    // Slots at or above heap_fill are never read, so no reset is needed there.
    // ------------------------------------------------------------------------
    logic signed [KEY_W-1:0] heap_key [DEPTH];
    logic [HANDLE_W-1:0]     heap_hdl [DEPTH];
    int                      heap_fill = 0;

    // results predicted at accept time, oldest first
    t_result pending_outcomes [$];

    // bookkeeping
    int idle_pct      = IDLE_PCT;
    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int push_count    = 0;
    int pop_count     = 0;
    int query_count   = 0;
    int pop_empty_hits = 0;
    int push_full_hits = 0;
    int peak_fill     = 0;

    function automatic void swap_slots(input int a, input int b);
        logic signed [KEY_W-1:0] k;
        logic [HANDLE_W-1:0]     h;
        k = heap_key[a];
        h = heap_hdl[a];
        heap_key[a] = heap_key[b];
        heap_hdl[a] = heap_hdl[b];
        heap_key[b] = k;
        heap_hdl[b] = h;
    endfunction

    // Applies one accepted request to the model heap and returns the result
    // the block must strobe for it.
    function automatic t_result apply_heap_request(input t_req_item req);
        t_result r;
        int      pos;
        int      up;
        int      lft;
        int      rgt;
        int      best;
        bit      moving;
        r = '0;
        r.status = ST_OK;
        case (req.req_type)
            REQ_PUSH: begin
                push_count++;
                if (heap_fill >= DEPTH) begin
                    // full heap: flagged, nothing stored
                    r.status = ST_PUSH_FULL;
                    push_full_hits++;
                end else begin
                    // append, then sift up while the parent is strictly smaller
                    pos = heap_fill;
                    heap_key[pos] = req.entry_key;
                    heap_hdl[pos] = req.entry_handle;  // all 16 handle bits kept
                    heap_fill++;
                    moving = 1'b1;
                    while (moving && pos > 0) begin
                        up = (pos - 1) / 2;
                        if (heap_key[up] < heap_key[pos]) begin
                            swap_slots(up, pos);
                            pos = up;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
            REQ_POP: begin
                pop_count++;
                if (heap_fill == 0) begin
                    r.status = ST_POP_EMPTY;
                    pop_empty_hits++;
                end else begin
                    r.popped_key    = heap_key[0];
                    r.popped_handle = heap_hdl[0];
                    heap_fill--;
                    heap_key[0] = heap_key[heap_fill];
                    heap_hdl[0] = heap_hdl[heap_fill];
                    // sift down toward the larger child, left wins a tie,
                    // stop unless that child is strictly larger
                    pos = 0;
                    moving = 1'b1;
                    while (moving && (2 * pos + 1 < heap_fill)) begin
                        lft  = 2 * pos + 1;
                        rgt  = lft + 1;
                        best = pos;
                        if (heap_key[lft] > heap_key[best])
                            best = lft;
                        if (rgt < heap_fill && heap_key[rgt] > heap_key[best])
                            best = rgt;
                        if (best == pos) begin
                            moving = 1'b0;
                        end else begin
                            swap_slots(pos, best);
                            pos = best;
                        end
                    end
                end
            end
            default: begin
                // query and the spare code leave the heap alone
                query_count++;
            end
        endcase
        if (heap_fill > 0) begin
            r.top_key    = heap_key[0];
            r.top_handle = heap_hdl[0];
        end
        r.is_empty    = (heap_fill == 0);
        r.entry_count = COUNT_W'(heap_fill);
        if (heap_fill > peak_fill)
            peak_fill = heap_fill;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: one transfer per call. start rises no earlier than the
    // edge after the previous transfer and drops in the step of the
    // transfer, so start never gets two assignments in one time step.
    // busy is sampled at the falling edge, so it holds its value through
    // the rising edge that follows.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_req_item req);
        t_result outcome;
        logic    was_busy;
        while ($urandom_range(99) < idle_pct)
            @(posedge i_clk);
        @(posedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        outcome = apply_heap_request(req);
        pending_outcomes = {pending_outcomes, outcome};
        start <= 1'b0;
        sent_count++;
    endtask

    task automatic send_fields(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                               input logic [HANDLE_W-1:0] hdl);
        t_req_item req;
        req.req_type     = op;
        req.entry_key    = key;
        req.entry_handle = hdl;
        send_request(req);
    endtask

    // keys: mostly full range, a good share from a narrow band to force ties,
    // some extremes
    function automatic logic signed [KEY_W-1:0] random_key();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $urandom_range(6) - 3;
            default: begin
                case ($urandom_range(3))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    2:       return '0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the block cannot be held off, so each strobe is a transfer
    // at the edge that ends its cycle. Fields are checked mid-cycle, at the
    // falling edge, where they are stable.
    // ------------------------------------------------------------------------
    t_result want;

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("result strobe with no request outstanding");
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                checked_count++;
                check_field("status",        32'(want.status),        32'(o_result.status));
                check_field("popped_key",    want.popped_key,         o_result.popped_key);
                check_field("popped_handle", 32'(want.popped_handle), 32'(o_result.popped_handle));
                check_field("top_key",       want.top_key,            o_result.top_key);
                check_field("top_handle",    32'(want.top_handle),    32'(o_result.top_handle));
                check_field("is_empty",      32'(want.is_empty),      32'(o_result.is_empty));
                check_field("entry_count",   32'(want.entry_count),   32'(o_result.entry_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corners: empty-heap pop and query, spare code, key and handle extremes,
    // equal keys on both sift directions, drain to empty and past it.
    task automatic test_directed_corners();
        send_fields(REQ_QUERY, '0, '0);
        send_fields(REQ_POP,   '0, '0);          // pop on empty
        send_fields(REQ_SPARE, KEY_MAX, 16'hFFFF);
        send_fields(REQ_PUSH,  '0,      16'h0000);
        send_fields(REQ_PUSH,  KEY_MAX, 16'hFFFF);
        send_fields(REQ_PUSH,  KEY_MIN, 16'h5555);
        send_fields(REQ_PUSH,  -1,      16'hAAAA);
        send_fields(REQ_PUSH,  1,       16'h0001);
        send_fields(REQ_PUSH,  KEY_MAX, 16'h8000); // tie with the root, must stay below
        send_fields(REQ_PUSH,  -1,      16'h1234); // another tie deeper down
        send_fields(REQ_QUERY, KEY_MIN, 16'h0000);
        send_fields(REQ_SPARE, '0,      16'h7FFF);
        repeat (7)
            send_fields(REQ_POP, '0, '0);
        send_fields(REQ_POP,   KEY_MAX, 16'hFFFF);  // empty again
        send_fields(REQ_PUSH,  KEY_MIN, 16'h7FFF);
        send_fields(REQ_QUERY, '0, '0);
        send_fields(REQ_POP,   '0, '0);
    endtask

    // Fill to capacity with rising keys so every push sifts to the root,
    // hit the full case, then drain with full-depth sift-downs.
    // No idling here: this is the long back-to-back stretch.
    task automatic test_fill_to_full();
        idle_pct = 0;
        for (int n = 0; n < DEPTH; n++)
            send_fields(REQ_PUSH, KEY_W'(n - DEPTH / 2), HANDLE_W'($urandom_range(16'hFFFF)));
        repeat (3)
            send_fields(REQ_PUSH, random_key(), HANDLE_W'($urandom_range(16'hFFFF)));
        send_fields(REQ_QUERY, '0, '0);
        for (int n = 0; n <= DEPTH; n++)
            send_fields(REQ_POP, random_key(), HANDLE_W'($urandom_range(16'hFFFF)));
        idle_pct = IDLE_PCT;
    endtask

    // One random burst; whatever is not push or pop is a query, one in four
    // of those with the spare code.
    task automatic random_burst(input int count, input int push_pct, input int pop_pct);
        t_req_item req;
        int        roll;
        for (int n = 0; n < count; n++) begin
            roll             = $urandom_range(99);
            req.entry_key    = random_key();
            req.entry_handle = HANDLE_W'($urandom_range(16'hFFFF));
            if (roll < push_pct)
                req.req_type = REQ_PUSH;
            else if (roll < push_pct + pop_pct)
                req.req_type = REQ_POP;
            else if ($urandom_range(3) == 0)
                req.req_type = REQ_SPARE;
            else
                req.req_type = REQ_QUERY;
            send_request(req);
        end
    endtask

    // Grow to full, churn near full, drain to empty, then churn at mid depth.
    task automatic test_random_traffic();
        random_burst(350, 90, 7);
        random_burst(300, 48, 45);
        random_burst(350, 10, 85);
        random_burst(400, 55, 38);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_fill_to_full();
        test_random_traffic();

        // every prediction must be consumed, then nothing else may strobe
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d push, %0d pop, %0d query), checked %0d results.",
                 sent_count, push_count, pop_count, query_count, checked_count);
        $display("Empty-heap pops: %0d, full-heap pushes: %0d, deepest fill: %0d entries.",
                 pop_empty_hits, push_full_hits, peak_fill);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT);
        $display("Timeout: %0d results still outstanding", pending_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
